FILE: hw/rtl/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;

  // Result kind codes
  typedef enum logic [2:0] {
    KIND_INFINITE = 3'd0,
    KIND_NONE     = 3'd1,
    KIND_LINEAR   = 3'd2,
    KIND_DOUBLE   = 3'd3,
    KIND_TWO      = 3'd4
  } kind_t;

  localparam int COEF_W = 16;  // Q8.8 coefficient
  localparam int ROOT_W = 32;  // Q16.16 root
  localparam int DISC_W = 35;  // signed discriminant b^2 - 4ac
  localparam int DMAG_W = 33;  // magnitude of a positive discriminant
  localparam int SQRT_W = 32;  // root bits of D * 2^30
  localparam int REM_W  = 35;  // square root remainder
  localparam int NUM_W  = 33;  // dividend magnitude
  localparam int DEN_W  = 16;  // divisor magnitude

endpackage

FILE: hw/rtl/qrs_div.sv
// Pipelined restoring divider of unsigned magnitudes, one quotient bit per stage.
`timescale 1ns / 1ps
module qrs_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [qrs_pkg::NUM_W-1:0] num,
  input  logic [qrs_pkg::DEN_W-1:0] den,
  output logic [qrs_pkg::NUM_W-1:0] quo
);

  localparam int NW = qrs_pkg::NUM_W;
  localparam int DW = qrs_pkg::DEN_W;

  typedef struct packed {
    logic [NW-1:0] n;
    logic [DW-1:0] d;
    logic [DW-1:0] r;
    logic [NW-1:0] q;
  } div_stage_t;

  div_stage_t st [1:NW];

  genvar k;
  generate
    for (k = 0; k < NW; k++) begin : g_stage
      div_stage_t cur;
      div_stage_t nxt;
      logic [DW:0] trial;
      logic [DW:0] diff;

      if (k == 0) begin : g_first
        assign cur = '{n: num, d: den, r: '0, q: '0};
      end else begin : g_rest
        assign cur = st[k];
      end

      // shift in next dividend bit, subtract divisor if it fits
      assign trial = {cur.r, cur.n[NW-1-k]};
      assign diff  = trial - {1'b0, cur.d};

      always_comb begin
        nxt = cur;
        if (!diff[DW]) begin
          nxt.r = diff[DW-1:0];
          nxt.q[NW-1-k] = 1'b1;
        end else begin
          nxt.r = trial[DW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          st[k+1] <= nxt;
        end
      end
    end
  endgenerate

  assign quo = st[NW].q;

endmodule

FILE: hw/rtl/quadratic_root_solver.sv
// Top level of the pipelined quadratic root solver.
// Pipeline from input transfer to result transfer: 1 input stage, 1 multiply
// stage, 1 discriminant stage, 32 square root stages, 1 dividend stage, 33
// divider stages, 1 output register. Throughput: one item per cycle when not stalled.
// A stall on the output freezes the whole pipeline. Reset (rst, synchronous)
// clears all valid bits; nothing else is held between items.
`timescale 1ns / 1ps
module quadratic_root_solver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        root_kind,
  output logic signed [qrs_pkg::ROOT_W-1:0] first_root,
  output logic signed [qrs_pkg::ROOT_W-1:0] second_root
);

  localparam int CW = qrs_pkg::COEF_W;
  localparam int SW = qrs_pkg::SQRT_W;
  localparam int RW = qrs_pkg::REM_W;
  localparam int NW = qrs_pkg::NUM_W;
  localparam int DW = qrs_pkg::DEN_W;
  localparam int XW = 2 * SW;

  typedef struct packed {
    logic                 v;
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
  } coef_stage_t;

  typedef struct packed {
    logic                   v;
    logic signed [CW-1:0]   a;
    logic signed [CW-1:0]   b;
    logic signed [CW-1:0]   c;
    logic signed [2*CW-1:0] bb;
    logic signed [2*CW-1:0] ac;
  } prod_stage_t;

  typedef struct packed {
    logic                         v;
    qrs_pkg::kind_t               kind;
    logic signed [CW-1:0]         a;
    logic signed [CW-1:0]         b;
    logic signed [CW-1:0]         c;
    logic [qrs_pkg::DMAG_W-1:0]   dmag;
    logic [SW-1:0]                root;
    logic [RW-1:0]                rem;
  } sqrt_stage_t;

  typedef struct packed {
    logic           v;
    qrs_pkg::kind_t kind;
    logic           neg1;
    logic           neg2;
  } side_t;

  logic        en;
  coef_stage_t s1;
  prod_stage_t s2;
  sqrt_stage_t sq [0:SW];
  side_t       side [0:NW];
  logic [NW-1:0] n1mag;
  logic [NW-1:0] n2mag;
  logic [DW-1:0] den;
  logic [NW-1:0] q1;
  logic [NW-1:0] q2;

  // whole pipeline advances unless the result waits
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // input and multiply stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.v <= 1'b0;
      s2.v <= 1'b0;
    end else if (en) begin
      s1.v <= in_valid;
      s2.v <= s1.v;
    end
    if (en) begin
      s1.a  <= coef_a;
      s1.b  <= coef_b;
      s1.c  <= coef_c;
      s2.a  <= s1.a;
      s2.b  <= s1.b;
      s2.c  <= s1.c;
      s2.bb <= s1.b * s1.b;
      s2.ac <= s1.a * s1.c;
    end
  end

  // discriminant and classification
  logic signed [qrs_pkg::DISC_W-1:0] disc;
  qrs_pkg::kind_t                    kind3;
  assign disc = qrs_pkg::DISC_W'(s2.bb) - (qrs_pkg::DISC_W'(s2.ac) <<< 2);

  always_comb begin
    if (s2.a == '0) begin
      if (s2.b == '0) begin
        kind3 = (s2.c == '0) ? qrs_pkg::KIND_INFINITE : qrs_pkg::KIND_NONE;
      end else begin
        kind3 = qrs_pkg::KIND_LINEAR;
      end
    end else if (disc == '0) begin
      kind3 = qrs_pkg::KIND_DOUBLE;
    end else if (disc[qrs_pkg::DISC_W-1]) begin
      kind3 = qrs_pkg::KIND_NONE;
    end else begin
      kind3 = qrs_pkg::KIND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].v <= 1'b0;
    end else if (en) begin
      sq[0].v <= s2.v;
    end
    if (en) begin
      sq[0].kind <= kind3;
      sq[0].a    <= s2.a;
      sq[0].b    <= s2.b;
      sq[0].c    <= s2.c;
      sq[0].dmag <= (kind3 == qrs_pkg::KIND_TWO) ? disc[qrs_pkg::DMAG_W-1:0] : '0;
      sq[0].root <= '0;
      sq[0].rem  <= '0;
    end
  end

  // square root of D * 2^30, one root bit per stage
  genvar k;
  generate
    for (k = 0; k < SW; k++) begin : g_sqrt
      localparam int P = SW - 1 - k;
      logic [XW-1:0] x;
      logic [RW-1:0] acc;
      logic [RW-1:0] trial;
      logic [RW:0]   diff;
      sqrt_stage_t   nxt;

      assign x     = {1'b0, sq[k].dmag, 30'b0};
      assign acc   = {sq[k].rem[RW-3:0], x[2*P+1 -: 2]};
      assign trial = {1'b0, sq[k].root, 2'b01};
      assign diff  = {1'b0, acc} - {1'b0, trial};

      always_comb begin
        nxt = sq[k];
        if (!diff[RW]) begin
          nxt.rem  = diff[RW-1:0];
          nxt.root = {sq[k].root[SW-2:0], 1'b1};
        end else begin
          nxt.rem  = acc;
          nxt.root = {sq[k].root[SW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          sq[k+1].v <= 1'b0;
        end else if (en) begin
          sq[k+1].v <= sq[k].v;
        end
        if (en) begin
          sq[k+1].kind <= nxt.kind;
          sq[k+1].a    <= nxt.a;
          sq[k+1].b    <= nxt.b;
          sq[k+1].c    <= nxt.c;
          sq[k+1].dmag <= nxt.dmag;
          sq[k+1].root <= nxt.root;
          sq[k+1].rem  <= nxt.rem;
        end
      end
    end
  endgenerate

  // dividends and divisor in sign/magnitude form
  localparam int EW = 35;
  sqrt_stage_t            sf;
  logic signed [EW-1:0]   nb;
  logic signed [EW-1:0]   nc;
  logic signed [EW-1:0]   sum1;
  logic signed [EW-1:0]   sum2;
  logic signed [EW-1:0]   sel1;
  logic signed [EW-1:0]   sel2;
  logic signed [CW:0]     dsel;
  logic [EW-1:0]          abs1;
  logic [EW-1:0]          abs2;
  logic [CW:0]            absd;

  assign sf   = sq[SW];
  assign nb   = -(EW'(sf.b) <<< 15);
  assign nc   = -(EW'(sf.c) <<< 16);
  assign sum1 = nb + EW'({1'b0, sf.root});
  assign sum2 = nb - EW'({1'b0, sf.root});

  always_comb begin
    case (sf.kind)
      qrs_pkg::KIND_LINEAR: begin
        sel1 = nc;
        sel2 = '0;
        dsel = (CW+1)'(sf.b);
      end
      qrs_pkg::KIND_DOUBLE: begin
        sel1 = nb;
        sel2 = nb;
        dsel = (CW+1)'(sf.a);
      end
      qrs_pkg::KIND_TWO: begin
        sel1 = sum1;
        sel2 = sum2;
        dsel = (CW+1)'(sf.a);
      end
      default: begin
        sel1 = '0;
        sel2 = '0;
        dsel = (CW+1)'(1);
      end
    endcase
  end

  assign abs1 = sel1[EW-1] ? EW'(-sel1) : EW'(sel1);
  assign abs2 = sel2[EW-1] ? EW'(-sel2) : EW'(sel2);
  assign absd = dsel[CW] ? (CW+1)'(-dsel) : (CW+1)'(dsel);

  always_ff @(posedge clk) begin
    if (rst) begin
      side[0].v <= 1'b0;
    end else if (en) begin
      side[0].v <= sf.v;
    end
    if (en) begin
      side[0].kind <= sf.kind;
      side[0].neg1 <= sel1[EW-1] ^ dsel[CW];
      side[0].neg2 <= sel2[EW-1] ^ dsel[CW];
      n1mag        <= abs1[NW-1:0];
      n2mag        <= abs2[NW-1:0];
      den          <= absd[DW-1:0];
    end
  end

  // two divider lanes, one for each root
  qrs_div u_div1 (.clk(clk), .en(en), .num(n1mag), .den(den), .quo(q1));
  qrs_div u_div2 (.clk(clk), .en(en), .num(n2mag), .den(den), .quo(q2));

  // sideband travels beside the dividers
  generate
    for (k = 0; k < NW; k++) begin : g_side
      always_ff @(posedge clk) begin
        if (rst) begin
          side[k+1].v <= 1'b0;
        end else if (en) begin
          side[k+1].v <= side[k].v;
        end
        if (en) begin
          side[k+1].kind <= side[k].kind;
          side[k+1].neg1 <= side[k].neg1;
          side[k+1].neg2 <= side[k].neg2;
        end
      end
    end
  endgenerate

  localparam int ROOT_WF = qrs_pkg::ROOT_W;

  // sign and saturate a quotient magnitude
  function automatic logic [ROOT_WF-1:0] sat_root(input logic [NW-1:0] q, input logic neg);
    logic [NW:0] ext;
    ext = {1'b0, q};
    if (neg) begin
      if (ext > (NW+1)'(64'h8000_0000)) begin
        sat_root = 32'h8000_0000;
      end else begin
        sat_root = ROOT_WF'(-ext);
      end
    end else begin
      if (ext > (NW+1)'(64'h7FFF_FFFF)) begin
        sat_root = 32'h7FFF_FFFF;
      end else begin
        sat_root = ext[ROOT_WF-1:0];
      end
    end
  endfunction

  side_t                  sl;
  logic [ROOT_WF-1:0]     r1;
  logic [ROOT_WF-1:0]     r2;
  assign sl = side[NW];
  assign r1 = sat_root(q1, sl.neg1);
  assign r2 = sat_root(q2, sl.neg2);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sl.v;
    end
    if (en) begin
      root_kind <= sl.kind;
      case (sl.kind)
        qrs_pkg::KIND_LINEAR: begin
          first_root  <= r1;
          second_root <= '0;
        end
        qrs_pkg::KIND_DOUBLE, qrs_pkg::KIND_TWO: begin
          first_root  <= r1;
          second_root <= r2;
        end
        default: begin
          first_root  <= '0;
          second_root <= '0;
        end
      endcase
    end
  end

endmodule
